// File: rtl/core/pcl_pkg.sv
// shared constants, codes and controller/datapath structs for the positional char list
package pcl_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);

  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_PRINT  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic cap;
    logic plan;
    logic mv;
    logic put;
    logic dec;
    logic get_rd;
    logic emit_code;
    logic emit_get;
    logic print_run;
  } cmd_t;

  typedef struct packed {
    logic bad;
    op_t  op;
    logic rem_zero;
    logic out_free;
    logic print_done;
  } sts_t;

endpackage

// File: rtl/core/pcl_if.sv
// valid/ready channel interfaces for operation items and result items
interface pcl_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcl_pkg::OP_W-1:0]    operation;
  logic [pcl_pkg::POS_W-1:0]   position;
  logic [pcl_pkg::CHAR_W-1:0]  character;

  modport source (output valid, output operation, output position, output character,
                  input ready);
  modport sink (input valid, input operation, input position, input character,
                output ready);
endinterface

interface pcl_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcl_pkg::CHAR_W-1:0]  value;
  logic [pcl_pkg::STAT_W-1:0]  status;
  logic [pcl_pkg::LEN_W-1:0]   length;
  logic                        last;

  modport source (output valid, output value, output status, output length, output last,
                  input ready);
  modport sink (input valid, input value, input status, input length, input last,
                output ready);
endinterface

// File: rtl/core/positional_char_list.sv
// top level of the positional char list: controller plus datapath
// Ordered list of up to 64 bytes addressed by 1-based position (0 acts as 1), kept
// contiguous in a single-port-write RAM. One operation item is handled at a time;
// the next item is accepted once the current one's last result is in the output
// register, which may still be waiting to be taken. Insert and delete move one
// stored element per cycle through the RAM, and print gives one result per cycle while
// the result side takes them. There is no clearing pass after reset.
module positional_char_list (
  input logic       clk,
  input logic       rst_n,
  pcl_in_if.sink    in_ch,
  pcl_out_if.source out_ch
);

  pcl_pkg::cmd_t cmd;
  pcl_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  pcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcl_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_ch.operation),
    .in_position  (in_ch.position),
    .in_character (in_ch.character),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_value    (out_ch.value),
    .out_status   (out_ch.status),
    .out_length   (out_ch.length),
    .out_last     (out_ch.last)
  );

endmodule

// File: rtl/core/pcl_ram.sv
// generic single write port ram with registered read and read enable
module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/pcl_dp.sv
// datapath: element store, count, shift and print sequencing, result register
module pcl_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pcl_pkg::OP_W-1:0]    in_operation,
  input  logic [pcl_pkg::POS_W-1:0]   in_position,
  input  logic [pcl_pkg::CHAR_W-1:0]  in_character,
  input  pcl_pkg::cmd_t               cmd,
  output pcl_pkg::sts_t               sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pcl_pkg::CHAR_W-1:0]  out_value,
  output logic [pcl_pkg::STAT_W-1:0]  out_status,
  output logic [pcl_pkg::LEN_W-1:0]   out_length,
  output logic                        out_last
);

  pcl_pkg::op_t                     op_r;
  logic [pcl_pkg::POS_W-1:0]        pos_r;
  logic [pcl_pkg::CHAR_W-1:0]       ch_r;
  logic [pcl_pkg::LEN_W-1:0]        count_r;
  pcl_pkg::status_t                 code_r;
  logic [pcl_pkg::LEN_W-1:0]        rem_r;
  logic [pcl_pkg::ADDR_W-1:0]       rd_addr_r;
  logic                             up_r;
  logic                             mv_valid_r;
  logic [pcl_pkg::ADDR_W-1:0]       mv_dst_r;
  logic                             pend_r;
  logic                             pend_last_r;
  logic                             out_valid_r;
  logic [pcl_pkg::CHAR_W-1:0]       out_value_r;
  pcl_pkg::status_t                 out_status_r;
  logic [pcl_pkg::LEN_W-1:0]        out_length_r;
  logic                             out_last_r;

  pcl_pkg::status_t                 code;
  logic [pcl_pkg::POS_W-1:0]        pos_m1;
  logic [pcl_pkg::ADDR_W-1:0]       pos_addr;
  logic [pcl_pkg::LEN_W-1:0]        count_m1;
  logic                             out_free;
  logic                             prt_rd;
  logic                             do_emit;
  logic                             ram_we;
  logic [pcl_pkg::ADDR_W-1:0]       ram_waddr;
  logic [pcl_pkg::CHAR_W-1:0]       ram_wdata;
  logic                             ram_re;
  logic [pcl_pkg::CHAR_W-1:0]       ram_rdata;

  assign pos_m1   = pos_r - pcl_pkg::POS_W'(1);
  assign pos_addr = pos_m1[pcl_pkg::ADDR_W-1:0];
  assign count_m1 = count_r - pcl_pkg::LEN_W'(1);

  always_comb begin
    code = pcl_pkg::ST_OK;
    unique case (op_r)
      pcl_pkg::OP_INSERT: begin
        if ({1'b0, pos_r} > ({1'b0, count_r} + 8'd1)) begin
          code = pcl_pkg::ST_INVALID;
        end else if (count_r == pcl_pkg::LEN_W'(pcl_pkg::CAPACITY)) begin
          code = pcl_pkg::ST_FULL;
        end
      end
      pcl_pkg::OP_DELETE, pcl_pkg::OP_GET: begin
        if (pos_r > count_r) begin
          code = pcl_pkg::ST_INVALID;
        end
      end
      pcl_pkg::OP_PRINT: begin
        if (count_r == '0) begin
          code = pcl_pkg::ST_EMPTY;
        end
      end
      default: code = pcl_pkg::ST_OK;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign prt_rd   = cmd.print_run && (rem_r != '0) && (!pend_r || out_free);
  assign do_emit  = cmd.print_run && pend_r && out_free;

  assign sts.bad        = (code != pcl_pkg::ST_OK);
  assign sts.op         = op_r;
  assign sts.rem_zero   = (rem_r == '0);
  assign sts.out_free   = out_free;
  assign sts.print_done = do_emit && pend_last_r;

  // one store write port: a shift move lands the cycle after its read
  assign ram_we    = mv_valid_r || cmd.put;
  assign ram_waddr = cmd.put ? pos_addr : mv_dst_r;
  assign ram_wdata = cmd.put ? ch_r : ram_rdata;
  assign ram_re    = cmd.mv || cmd.get_rd || prt_rd;

  pcl_ram #(
    .WIDTH (pcl_pkg::CHAR_W),
    .DEPTH (pcl_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mv_valid_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mv_valid_r <= cmd.mv;

      if (cmd.cap) begin
        op_r  <= pcl_pkg::op_t'(in_operation);
        pos_r <= (in_position == '0) ? pcl_pkg::POS_W'(1) : in_position;
        ch_r  <= in_character;
      end

      if (cmd.plan) begin
        code_r <= code;
        pend_r <= 1'b0;
        unique case (op_r)
          pcl_pkg::OP_INSERT: begin
            rem_r     <= count_r - pos_m1;
            rd_addr_r <= count_m1[pcl_pkg::ADDR_W-1:0];
            up_r      <= 1'b1;
          end
          pcl_pkg::OP_DELETE: begin
            rem_r     <= count_r - pos_r;
            rd_addr_r <= pos_r[pcl_pkg::ADDR_W-1:0];
            up_r      <= 1'b0;
          end
          pcl_pkg::OP_GET: begin
            rem_r     <= '0;
            rd_addr_r <= pos_addr;
            up_r      <= 1'b0;
          end
          pcl_pkg::OP_PRINT: begin
            rem_r     <= count_r;
            rd_addr_r <= '0;
            up_r      <= 1'b0;
          end
          default: begin
            rem_r     <= '0;
            rd_addr_r <= '0;
            up_r      <= 1'b0;
          end
        endcase
      end else if (cmd.mv) begin
        rem_r     <= rem_r - pcl_pkg::LEN_W'(1);
        mv_dst_r  <= up_r ? rd_addr_r + pcl_pkg::ADDR_W'(1)
                          : rd_addr_r - pcl_pkg::ADDR_W'(1);
        rd_addr_r <= up_r ? rd_addr_r - pcl_pkg::ADDR_W'(1)
                          : rd_addr_r + pcl_pkg::ADDR_W'(1);
      end else if (prt_rd) begin
        rem_r       <= rem_r - pcl_pkg::LEN_W'(1);
        rd_addr_r   <= rd_addr_r + pcl_pkg::ADDR_W'(1);
        pend_r      <= 1'b1;
        pend_last_r <= (rem_r == pcl_pkg::LEN_W'(1));
      end else if (do_emit) begin
        pend_r <= 1'b0;
      end

      if (cmd.put) begin
        count_r <= count_r + pcl_pkg::LEN_W'(1);
      end else if (cmd.dec) begin
        count_r <= count_m1;
      end

      if (cmd.emit_code) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= '0;
        out_status_r <= code_r;
        out_length_r <= count_r;
        out_last_r   <= 1'b1;
      end else if (cmd.emit_get) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= ram_rdata;
        out_status_r <= pcl_pkg::ST_OK;
        out_length_r <= count_r;
        out_last_r   <= 1'b1;
      end else if (do_emit) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= ram_rdata;
        out_status_r <= pcl_pkg::ST_OK;
        out_length_r <= count_r;
        out_last_r   <= pend_last_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_length = out_length_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pcl_pkg::LEN_W'(pcl_pkg::CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) ||
    (count_r == $past(count_r) + pcl_pkg::LEN_W'(1)) ||
    (count_r == $past(count_r) - pcl_pkg::LEN_W'(1)))
    else $error("element count changed by more than one");

  a_write_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mv_valid_r && cmd.put))
    else $error("shift write and insert write in the same cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_code || cmd.emit_get || do_emit) |-> out_free)
    else $error("result loaded over an item not yet taken");
`endif

endmodule

// File: rtl/core/pcl_ctrl.sv
// controller state machine sequencing one operation item at a time
module pcl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcl_pkg::sts_t sts,
  output pcl_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_MOVE,
    S_PUT,
    S_RESP,
    S_GET_RD,
    S_GET_OUT,
    S_PRINT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan = 1'b1;
        if (sts.bad) begin
          state_nxt = S_RESP;
        end else begin
          unique case (sts.op)
            pcl_pkg::OP_INSERT, pcl_pkg::OP_DELETE: state_nxt = S_MOVE;
            pcl_pkg::OP_GET:                        state_nxt = S_GET_RD;
            pcl_pkg::OP_PRINT:                      state_nxt = S_PRINT;
            default:                                state_nxt = S_RESP;
          endcase
        end
      end
      S_MOVE: begin
        if (!sts.rem_zero) begin
          cmd.mv = 1'b1;
        end else if (sts.op == pcl_pkg::OP_INSERT) begin
          state_nxt = S_PUT;
        end else begin
          cmd.dec   = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_code = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GET_RD: begin
        cmd.get_rd = 1'b1;
        state_nxt  = S_GET_OUT;
      end
      S_GET_OUT: begin
        if (sts.out_free) begin
          cmd.emit_get = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PRINT: begin
        cmd.print_run = 1'b1;
        if (sts.print_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
